FILE: design/cst_pkg.sv
package cst_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  localparam logic [1:0] TYPE_IDENT  = 2'd0;
  localparam logic [1:0] TYPE_SYMBOL = 2'd1;
  localparam logic [1:0] TYPE_NUMBER = 2'd2;
  localparam logic [1:0] TYPE_STRING = 2'd3;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam int unsigned MAX_RES = 3;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_IDENT = 5'b00010,
    MODE_INT   = 5'b00100,
    MODE_FRAC  = 5'b01000,
    MODE_STR   = 5'b10000
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] token_type;
    logic       first_char;
    logic       last_char;
    logic       unterminated;
  } lex_res_t;

  function automatic lex_res_t make_res(logic [7:0] c, logic [1:0] t, logic f, logic l,
                                        logic u);
    lex_res_t r;
    r.char_out     = c;
    r.token_type   = t;
    r.first_char   = f;
    r.last_char    = l;
    r.unterminated = u;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_symbol(logic [7:0] c);
    return (c == CH_EQ) || (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA);
  endfunction

  function automatic logic [1:0] mode_type(lex_mode_t m);
    if (m == MODE_IDENT) return TYPE_IDENT;
    if (m == MODE_STR) return TYPE_STRING;
    return TYPE_NUMBER;
  endfunction

endpackage

FILE: design/character_stream_tokenizer_unit.sv
// A request's first result appears on the output in the cycle after it is taken.
// Throughput: one request per cycle while each causes at most one result and m_tready is
//   high; a request that causes several results holds the input while the buffer drains.
// The last char of an identifier or number waits for the next request before it is sent.
// Reset (rst, synchronous, active high) returns the lexer to idle and empties the buffer.
module character_stream_tokenizer_unit
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] char_in
  input  logic       s_tuser,  // [0] opcode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [7:0] char_out
  output logic [3:0] m_tuser,  // [1:0] token_type, [2] first_char, [3] unterminated
  output logic       m_tlast   // last_char
);

  lex_res_t [MAX_RES-1:0] step_res;
  logic [1:0]             step_count;
  lex_res_t [MAX_RES-1:0] buf_res;
  logic [1:0]             cnt;
  logic [1:0]             head;
  logic                   take;
  logic                   out_fire;
  lex_res_t               cur;

  assign out_fire = m_tvalid & m_tready;
  assign s_tready = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);
  assign take     = s_tvalid & s_tready;

  cst_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .opcode    (s_tuser),
    .char_in   (s_tdata),
    .res       (step_res),
    .res_count (step_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      head <= 2'd0;
    end else if (take) begin
      cnt  <= step_count;
      head <= 2'd0;
    end else if (out_fire) begin
      cnt  <= cnt - 2'd1;
      head <= head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf_res <= step_res;
    end
  end

  assign cur      = buf_res[head];
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = cur.char_out;
  assign m_tuser  = {cur.unterminated, cur.first_char, cur.token_type};
  assign m_tlast  = cur.last_char;

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, head} + {1'b0, cnt}) <= 3'd3)
    else $error("result buffer overrun");

  a_unterm: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3]) |-> (m_tlast && m_tuser[1:0] == TYPE_STRING))
    else $error("unterminated flag on a non-closing or non-string character");

  a_symbol: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == TYPE_SYMBOL) |-> (m_tuser[2] && m_tlast))
    else $error("symbol not a single-character token");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && !s_tready) |=> $stable(cnt))
    else $error("buffer count moved while stalled");

endmodule

FILE: design/cst_lexer.sv
module cst_lexer
  import cst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic                   opcode,
  input  logic [7:0]             char_in,
  output lex_res_t [MAX_RES-1:0] res,
  output logic [1:0]             res_count
);

  lex_mode_t  mode, mode_next;
  logic [7:0] held_char, held_char_next;
  logic       held_valid, held_valid_next;
  logic       held_is_first, held_is_first_next;
  logic       dot_waiting, dot_waiting_next;

  always_comb begin
    logic [1:0] n;
    logic       open_new;
    n                  = 2'd0;
    open_new           = 1'b0;
    res                = '0;
    mode_next          = mode;
    held_char_next     = held_char;
    held_valid_next    = held_valid;
    held_is_first_next = held_is_first;
    dot_waiting_next   = dot_waiting;

    if (opcode == OP_EOF) begin
      if (held_valid) begin
        res[n] = make_res(held_char, mode_type(mode), held_is_first, 1'b1, mode == MODE_STR);
        n = n + 2'd1;
      end
      held_valid_next    = 1'b0;
      held_is_first_next = 1'b0;
      held_char_next     = '0;
      dot_waiting_next   = 1'b0;
      mode_next          = MODE_IDLE;
    end else begin
      // pending dot: kept on any nonzero byte
      if (mode == MODE_INT && dot_waiting) begin
        dot_waiting_next = 1'b0;
        if (char_in != 8'h00) begin
          res[n] = make_res(held_char_next, TYPE_NUMBER, held_is_first_next, 1'b0, 1'b0);
          n = n + 2'd1;
          held_char_next     = CH_DOT;
          held_valid_next    = 1'b1;
          held_is_first_next = 1'b0;
          mode_next          = MODE_FRAC;
        end else begin
          if (held_valid_next) begin
            res[n] = make_res(held_char_next, TYPE_NUMBER, held_is_first_next, 1'b1, 1'b0);
            n = n + 2'd1;
          end
          held_valid_next    = 1'b0;
          held_is_first_next = 1'b0;
          held_char_next     = '0;
          mode_next          = MODE_IDLE;
        end
      end

      case (mode_next)
        MODE_IDENT, MODE_INT, MODE_FRAC: begin
          if (is_digit(char_in) ||
              (mode_next == MODE_IDENT && (is_alpha(char_in) || char_in == CH_UNDER))) begin
            res[n] = make_res(held_char_next, mode_type(mode_next), held_is_first_next,
                              1'b0, 1'b0);
            n = n + 2'd1;
            held_char_next     = char_in;
            held_valid_next    = 1'b1;
            held_is_first_next = 1'b0;
          end else if (mode_next == MODE_INT && char_in == CH_DOT) begin
            dot_waiting_next = 1'b1;
          end else begin
            if (held_valid_next) begin
              res[n] = make_res(held_char_next, mode_type(mode_next), held_is_first_next,
                                1'b1, 1'b0);
              n = n + 2'd1;
            end
            held_valid_next    = 1'b0;
            held_is_first_next = 1'b0;
            held_char_next     = '0;
            dot_waiting_next   = 1'b0;
            mode_next          = MODE_IDLE;
            open_new           = 1'b1;
          end
        end
        MODE_STR: begin
          res[n] = make_res(held_char_next, TYPE_STRING, held_is_first_next, 1'b0, 1'b0);
          n = n + 2'd1;
          if (char_in == CH_QUOTE) begin
            res[n] = make_res(char_in, TYPE_STRING, 1'b0, 1'b1, 1'b0);
            n = n + 2'd1;
            held_valid_next    = 1'b0;
            held_char_next     = '0;
            held_is_first_next = 1'b0;
            mode_next          = MODE_IDLE;
          end else begin
            held_char_next     = char_in;
            held_valid_next    = 1'b1;
            held_is_first_next = 1'b0;
          end
        end
        default: begin
          mode_next        = MODE_IDLE;
          held_valid_next  = 1'b0;
          dot_waiting_next = 1'b0;
          open_new         = 1'b1;
        end
      endcase

      if (open_new) begin
        if (is_alpha(char_in)) begin
          mode_next          = MODE_IDENT;
          held_char_next     = char_in;
          held_valid_next    = 1'b1;
          held_is_first_next = 1'b1;
        end else if (is_symbol(char_in)) begin
          res[n] = make_res(char_in, TYPE_SYMBOL, 1'b1, 1'b1, 1'b0);
          n = n + 2'd1;
        end else if (char_in == CH_MINUS || char_in == CH_PLUS || is_digit(char_in)) begin
          mode_next          = MODE_INT;
          held_char_next     = char_in;
          held_valid_next    = 1'b1;
          held_is_first_next = 1'b1;
        end else if (char_in == CH_QUOTE) begin
          mode_next          = MODE_STR;
          held_char_next     = char_in;
          held_valid_next    = 1'b1;
          held_is_first_next = 1'b1;
        end
      end
    end
    res_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      held_char     <= '0;
      held_valid    <= 1'b0;
      held_is_first <= 1'b0;
      dot_waiting   <= 1'b0;
    end else if (take) begin
      mode          <= mode_next;
      held_char     <= held_char_next;
      held_valid    <= held_valid_next;
      held_is_first <= held_is_first_next;
      dot_waiting   <= dot_waiting_next;
    end
  end

endmodule

FILE: verif/tokenizer_checker.sv
`timescale 1ns / 1ps

module tokenizer_checker
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic [3:0] m_tuser,
  input  logic       m_tlast,
  output int         mismatches,
  output int         outstanding,
  output int         chars_checked
);

  lex_res_t  token_chars[$];
  lex_mode_t scan_mode;
  logic [7:0] pend_char;
  logic       pend_valid;
  logic       pend_first;
  logic       dot_pending;
  int         err_cnt;
  int         seen_cnt;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_single_symbol(logic [7:0] c);
    return c == CH_EQ || c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA;
  endfunction

  function automatic logic [1:0] kind_of_mode(lex_mode_t m);
    case (m)
      MODE_IDENT: return TYPE_IDENT;
      MODE_STR:   return TYPE_STRING;
      default:    return TYPE_NUMBER;
    endcase
  endfunction

  task automatic push_char(logic [7:0] c, logic [1:0] t, logic f, logic l, logic u);
    lex_res_t r;
    r.char_out     = c;
    r.token_type   = t;
    r.first_char   = f;
    r.last_char    = l;
    r.unterminated = u;
    token_chars = {token_chars, r};
  endtask

  task automatic hold_char(logic [7:0] c, logic f);
    pend_char  = c;
    pend_valid = 1'b1;
    pend_first = f;
  endtask

  task automatic extend_token(logic [7:0] c);
    push_char(pend_char, kind_of_mode(scan_mode), pend_first, 1'b0, 1'b0);
    hold_char(c, 1'b0);
  endtask

  task automatic close_token(logic unterm);
    if (pend_valid)
      push_char(pend_char, kind_of_mode(scan_mode), pend_first, 1'b1, unterm);
    pend_valid  = 1'b0;
    pend_first  = 1'b0;
    pend_char   = '0;
    dot_pending = 1'b0;
    scan_mode   = MODE_IDLE;
  endtask

  task automatic predict_request(logic op, logic [7:0] b);
    logic opens;
    opens = 1'b1;
    if (op == OP_EOF) begin
      close_token(scan_mode == MODE_STR);
      return;
    end
    if (scan_mode == MODE_INT && dot_pending) begin
      dot_pending = 1'b0;
      if (b != 8'h00) begin
        push_char(pend_char, TYPE_NUMBER, pend_first, 1'b0, 1'b0);
        hold_char(CH_DOT, 1'b0);
        scan_mode = MODE_FRAC;
      end else begin
        close_token(1'b0);
      end
    end
    case (scan_mode)
      MODE_IDENT: begin
        if (is_letter(b) || is_numeral(b) || b == CH_UNDER) begin
          extend_token(b);
          opens = 1'b0;
        end else begin
          close_token(1'b0);
        end
      end
      MODE_INT: begin
        if (is_numeral(b)) begin
          extend_token(b);
          opens = 1'b0;
        end else if (b == CH_DOT) begin
          dot_pending = 1'b1;
          opens = 1'b0;
        end else begin
          close_token(1'b0);
        end
      end
      MODE_FRAC: begin
        if (is_numeral(b)) begin
          extend_token(b);
          opens = 1'b0;
        end else begin
          close_token(1'b0);
        end
      end
      MODE_STR: begin
        push_char(pend_char, TYPE_STRING, pend_first, 1'b0, 1'b0);
        if (b == CH_QUOTE) begin
          push_char(b, TYPE_STRING, 1'b0, 1'b1, 1'b0);
          pend_valid = 1'b0;
          pend_char  = '0;
          pend_first = 1'b0;
          scan_mode  = MODE_IDLE;
        end else begin
          hold_char(b, 1'b0);
        end
        opens = 1'b0;
      end
      default: begin
        scan_mode   = MODE_IDLE;
        pend_valid  = 1'b0;
        dot_pending = 1'b0;
      end
    endcase
    if (!opens) return;
    if (is_letter(b)) begin
      scan_mode = MODE_IDENT;
      hold_char(b, 1'b1);
    end else if (is_single_symbol(b)) begin
      push_char(b, TYPE_SYMBOL, 1'b1, 1'b1, 1'b0);
    end else if (b == CH_MINUS || b == CH_PLUS || is_numeral(b)) begin
      scan_mode = MODE_INT;
      hold_char(b, 1'b1);
    end else if (b == CH_QUOTE) begin
      scan_mode = MODE_STR;
      hold_char(b, 1'b1);
    end
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  initial begin
    scan_mode   = MODE_IDLE;
    pend_char   = '0;
    pend_valid  = 1'b0;
    pend_first  = 1'b0;
    dot_pending = 1'b0;
    err_cnt     = 0;
    seen_cnt    = 0;
  end

  always @(posedge clk) begin
    lex_res_t exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        seen_cnt++;
        if (token_chars.size() == 0) begin
          $error("unexpected result: char 0x%0h, tuser 0x%0h, tlast %0b",
                 m_tdata, m_tuser, m_tlast);
          err_cnt++;
        end else begin
          exp_r = token_chars.pop_front();
          check_field("char_out", exp_r.char_out, m_tdata);
          check_field("token_type", exp_r.token_type, m_tuser[1:0]);
          check_field("first_char", exp_r.first_char, m_tuser[2]);
          check_field("unterminated", exp_r.unterminated, m_tuser[3]);
          check_field("last_char", exp_r.last_char, m_tlast);
        end
      end
    end
    mismatches    <= err_cnt;
    outstanding   <= token_chars.size();
    chars_checked <= seen_cnt;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cst_pkg::*;

  localparam int RANDOM_PER_PHASE = 110;
  localparam int N_DIRECTED = 27;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tuser = OP_BYTE;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;
  logic       m_tlast;

  int mismatches;
  int outstanding;
  int chars_checked;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int requests_sent = 0;

  // {opcode, char}
  logic [8:0] directed_seq [N_DIRECTED] = '{
    {OP_EOF, 8'hFF},
    {OP_BYTE, "a"}, {OP_BYTE, "Z"}, {OP_BYTE, CH_UNDER}, {OP_BYTE, "9"},
    {OP_BYTE, CH_EQ}, {OP_BYTE, CH_LPAREN}, {OP_BYTE, CH_RPAREN}, {OP_BYTE, CH_COMMA},
    {OP_BYTE, CH_MINUS}, {OP_BYTE, "1"}, {OP_BYTE, CH_DOT}, {OP_BYTE, "5"},
    {OP_BYTE, CH_DOT},
    {OP_BYTE, "7"}, {OP_BYTE, CH_DOT}, {OP_BYTE, 8'h00},
    {OP_BYTE, CH_PLUS}, {OP_BYTE, CH_QUOTE}, {OP_EOF, 8'h00},
    {OP_BYTE, CH_QUOTE}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'hFF}, {OP_EOF, 8'h80},
    {OP_BYTE, "4"}, {OP_BYTE, CH_DOT}, {OP_EOF, 8'h7F}
  };

  character_stream_tokenizer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  tokenizer_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .chars_checked (chars_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] rand_letter();
    int c;
    c = $urandom_range(51);
    return (c < 26) ? 8'("A" + c) : 8'("a" + c - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_ident_tail();
    int r;
    r = $urandom_range(62);
    if (r < 52) return rand_letter();
    if (r < 62) return rand_digit();
    return CH_UNDER;
  endfunction

  task automatic send_request(logic op, logic [7:0] ch);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_random_token();
    int kind;
    int r;
    logic [7:0] ch;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_request(OP_BYTE, rand_letter());
      repeat ($urandom_range(6)) send_request(OP_BYTE, rand_ident_tail());
    end else if (kind < 45) begin
      if ($urandom_range(2) == 0)
        send_request(OP_BYTE, $urandom_range(1) ? CH_PLUS : CH_MINUS);
      else
        send_request(OP_BYTE, rand_digit());
      repeat ($urandom_range(4)) send_request(OP_BYTE, rand_digit());
      r = $urandom_range(5);
      if (r >= 1) send_request(OP_BYTE, CH_DOT);
      if (r == 1) send_request(OP_BYTE, 8'h00);
      else if (r == 2) send_request(OP_EOF, 8'($urandom));
      else if (r >= 3) begin
        repeat ($urandom_range(3)) send_request(OP_BYTE, rand_digit());
        if (r == 5) send_request(OP_BYTE, CH_DOT);
      end
    end else if (kind < 60) begin
      send_request(OP_BYTE, CH_QUOTE);
      repeat ($urandom_range(6)) begin
        ch = 8'($urandom);
        if (ch == CH_QUOTE) ch = 8'h00;
        send_request(OP_BYTE, ch);
      end
      if ($urandom_range(99) < 85) send_request(OP_BYTE, CH_QUOTE);
      else send_request(OP_EOF, 8'($urandom));
    end else if (kind < 75) begin
      case ($urandom_range(3))
        0: ch = CH_EQ;
        1: ch = CH_LPAREN;
        2: ch = CH_RPAREN;
        default: ch = CH_COMMA;
      endcase
      send_request(OP_BYTE, ch);
    end else if (kind < 85) begin
      send_request(OP_BYTE, " ");
    end else if (kind < 91) begin
      send_request(OP_EOF, 8'($urandom));
    end else begin
      send_request(OP_BYTE, 8'($urandom));
    end
  endtask

  task automatic run_random_phase(int src_pct, int dst_pct);
    int target;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    target = requests_sent + RANDOM_PER_PHASE;
    while (requests_sent < target) send_random_token();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 8;
    dst_idle_pct = 49;
    foreach (directed_seq[i]) send_request(directed_seq[i][8], directed_seq[i][7:0]);

    run_random_phase(8, 49);
    run_random_phase(49, 8);
    run_random_phase(0, 0);
    send_request(OP_EOF, 8'h00);

    @(negedge clk);
    s_tvalid <= 1'b0;
    dst_idle_pct = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests: directed edge cases, then random identifiers, numbers,",
             requests_sent);
    $display("strings, symbols and noise under three idling regimes; %0d results compared.",
             chars_checked);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: character_stream_tokenizer_unit.f
design/cst_pkg.sv
design/cst_lexer.sv
design/character_stream_tokenizer_unit.sv
verif/tokenizer_checker.sv
verif/testbench.sv
